// ===== rtl/ptf_pkg.sv =====
// Package for the pulse-period tachometer filter.
// Field widths, register reset values, status and state codes, divider request type.
// No dependencies.
package ptf_pkg;

    // Defaults for the top-level parameters
    localparam int RING_DEPTH_DEF = 8;
    localparam int TIMER_BITS_DEF = 16;

    // Field and register widths
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int TCH_W      = 24;
    localparam int MAX_HZ_W   = 10;
    localparam int RATIO_W    = 4;
    localparam int TIMEOUT_W  = 16;
    localparam int CAP_W      = 16;
    localparam int MS_W       = 32;
    localparam int FREQ_W     = 18;
    localparam int STATUS_W   = 3;
    localparam int HELD_W     = 4;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_W     = FREQ_W + RATIO_W;

    // Serial divider: dividend width and step counter width
    localparam int DIV_NUM_W  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    // Register reset values
    localparam logic [TCH_W-1:0]     TCH_RST     = TCH_W'(8000000);
    localparam logic [MAX_HZ_W-1:0]  MAX_HZ_RST  = MAX_HZ_W'(400);
    localparam logic [RATIO_W-1:0]   RATIO_RST   = RATIO_W'(2);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(500);

    // Command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CLOCK_HZ = 2'd0,
        CFG_MAX_ACCEPT_HZ  = 2'd1,
        CFG_RATIO_LIMIT    = 2'd2,
        CFG_TIMEOUT_MS     = 2'd3
    } t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED      = 3'd0,
        ST_ZERO_PERIOD   = 3'd1,
        ST_TOO_FAST      = 3'd2,
        ST_JUMP          = 3'd3,
        ST_QUERY_OK      = 3'd4,
        ST_QUERY_TIMEOUT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_SAMPLE,
        S_CHECK,
        S_JUMP,
        S_DIV_MEAN,
        S_DONE
    } t_state;

    // Divider request: start pulse and number of quotient bits to produce
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

endpackage

// ===== rtl/pulse_period_tachometer_filter.sv =====
// Pulse-period tachometer: period to frequency, plausibility checks, moving average.
// Steps: a query or zero period goes from decode to the output; an edge first divides for the
// sample frequency, then checks too fast and jump; an accepted sample has the bit-serial divider form the ring mean.
// One item in flight; the next is taken the cycle after the result enters the output register.
// Synchronous active-low reset: config to defaults, ring empty, average and timestamps zero.
module pulse_period_tachometer_filter
    import ptf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_cmd,
    input  logic [CAP_W-1:0]     i_capture_value,
    input  logic [MS_W-1:0]      i_now_ms,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [FREQ_W-1:0]    o_filtered_freq,
    output logic [STATUS_W-1:0]  o_status,
    output logic [HELD_W-1:0]    o_samples_held
);

    localparam int PW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILLW  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = FREQ_W + FILLW;
    localparam int CAPW   = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;

    // configuration registers
    logic [TCH_W-1:0]     r_tch;
    logic [MAX_HZ_W-1:0]  r_max_hz;
    logic [RATIO_W-1:0]   r_ratio;
    logic [TIMEOUT_W-1:0] r_timeout;

    // control and architectural state
    t_state               r_state, n_state;
    logic [CAPW-1:0]      r_prev;
    logic [MS_W-1:0]      r_last_ms;
    logic [PW-1:0]        r_pos;
    logic [FILLW-1:0]     r_fill;
    logic [SUM_W-1:0]     r_sum;
    logic [FREQ_W-1:0]    r_avg;
    logic                 r_out_valid;

    // item payload and working registers
    logic                 r_cmd;
    logic [CAP_W-1:0]     r_cap;
    logic [MS_W-1:0]      r_now;
    logic [DIV_NUM_W-1:0] r_sample;
    logic [PROD_W-1:0]    r_prod_hi;
    logic [PROD_W-1:0]    r_prod_lo;
    t_status              r_status;
    logic [FREQ_W-1:0]    r_out_freq;
    t_status              r_out_status;
    logic [HELD_W-1:0]    r_out_held;

    // combinational datapath
    logic [TIMER_BITS-1:0]     w_period;
    logic                      w_zero_period;
    logic                      w_timed_out;
    logic                      w_too_fast;
    logic                      w_jump;
    logic                      w_full;
    logic [FILLW-1:0]          w_fill_next;
    logic [PW-1:0]             w_pos_next;
    logic [SUM_W-1:0]          w_sum_next;
    logic [FREQ_W-1:0]         w_sample18;
    logic [FREQ_W-1:0]         w_ram_rdata;
    logic [FILLW+HELD_W-1:0]   w_held_ext;
    logic                      w_out_free;

    // FSM outputs
    logic                      w_ram_we;
    logic                      w_out_load;
    t_div_req                  w_div_req;
    logic [DIV_NUM_W-1:0]      w_div_dividend;
    logic [TIMER_BITS-1:0]     w_div_divisor;
    logic                      w_div_done;
    logic [DIV_NUM_W-1:0]      w_div_quo;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tch     <= TCH_RST;
            r_max_hz  <= MAX_HZ_RST;
            r_ratio   <= RATIO_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TIMER_CLOCK_HZ: r_tch     <= i_cfg_data[TCH_W-1:0];
                CFG_MAX_ACCEPT_HZ:  r_max_hz  <= i_cfg_data[MAX_HZ_W-1:0];
                CFG_RATIO_LIMIT:    r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_TIMEOUT_MS:     r_timeout <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath decode
    always_comb begin
        w_period      = TIMER_BITS'(r_cap[CAPW-1:0]) - TIMER_BITS'(r_prev);
        w_zero_period = (w_period == '0);
        w_timed_out   = ((r_now - r_last_ms) > MS_W'(r_timeout));
        w_too_fast    = (r_sample > {{(DIV_NUM_W-MAX_HZ_W-FRAC_BITS){1'b0}},
                                     r_max_hz, {FRAC_BITS{1'b0}}});
        w_sample18    = r_sample[FREQ_W-1:0];
        w_jump        = (r_fill != '0) && (r_avg != '0) &&
                        ((PROD_W'(w_sample18) > r_prod_hi) ||
                         (r_prod_lo < PROD_W'(r_avg)));
        w_full        = (r_fill == FILLW'(RING_DEPTH));
        w_fill_next   = w_full ? r_fill : r_fill + 1'b1;
        w_pos_next    = (r_pos == PW'(RING_DEPTH - 1)) ? '0 : r_pos + 1'b1;
        w_sum_next    = r_sum + SUM_W'(w_sample18)
                        - (w_full ? SUM_W'(w_ram_rdata) : '0);
        w_held_ext    = {{HELD_W{1'b0}}, r_fill};
        w_out_free    = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (r_cmd == CMD_QUERY || w_zero_period) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV_SAMPLE;
                end
            end
            S_DIV_SAMPLE: if (w_div_done) n_state = S_CHECK;
            S_CHECK:      n_state = w_too_fast ? S_DONE : S_JUMP;
            S_JUMP:       n_state = w_jump ? S_DONE : S_DIV_MEAN;
            S_DIV_MEAN:   if (w_div_done) n_state = S_DONE;
            S_DONE:       if (w_out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        w_ram_we        = 1'b0;
        w_out_load      = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.steps = DIV_CNT_W'(DIV_NUM_W);
        w_div_dividend  = {r_tch, {FRAC_BITS{1'b0}}};
        w_div_divisor   = w_period;
        unique case (r_state)
            S_DECODE: begin
                w_div_req.start = (r_cmd == CMD_EDGE) && !w_zero_period;
            end
            S_JUMP: begin
                w_ram_we        = !w_jump;
                w_div_req.start = !w_jump;
                w_div_req.steps = DIV_CNT_W'(SUM_W);
                w_div_dividend  = {w_sum_next, {(DIV_NUM_W-SUM_W){1'b0}}};
                w_div_divisor   = TIMER_BITS'(w_fill_next);
            end
            S_DONE:  w_out_load = w_out_free;
            default: ;
        endcase
    end

    // state register and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '0;
            r_last_ms <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_avg     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_DECODE: begin
                    if (r_cmd == CMD_QUERY) begin
                        if (w_timed_out) begin
                            r_avg  <= '0;
                            r_pos  <= '0;
                            r_fill <= '0;
                            r_sum  <= '0;
                        end
                    end else begin
                        r_prev <= r_cap[CAPW-1:0];
                    end
                end
                S_JUMP: begin
                    if (!w_jump) begin
                        r_pos     <= w_pos_next;
                        r_fill    <= w_fill_next;
                        r_sum     <= w_sum_next;
                        r_last_ms <= r_now;
                    end
                end
                S_DIV_MEAN: begin
                    if (w_div_done) r_avg <= w_div_quo[FREQ_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // item payload, products and status
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_cmd;
            r_cap <= i_capture_value;
            r_now <= i_now_ms;
        end
        unique case (r_state)
            S_DECODE: begin
                if (r_cmd == CMD_QUERY) begin
                    r_status <= w_timed_out ? ST_QUERY_TIMEOUT : ST_QUERY_OK;
                end else if (w_zero_period) begin
                    r_status <= ST_ZERO_PERIOD;
                end
            end
            S_DIV_SAMPLE: if (w_div_done) r_sample <= w_div_quo;
            S_CHECK: begin
                if (w_too_fast) r_status <= ST_TOO_FAST;
                r_prod_hi <= PROD_W'(r_ratio) * PROD_W'(r_avg);
                r_prod_lo <= PROD_W'(w_sample18) * PROD_W'(r_ratio);
            end
            S_JUMP: r_status <= w_jump ? ST_JUMP : ST_ACCEPTED;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_freq   <= r_avg;
            r_out_status <= r_status;
            r_out_held   <= w_held_ext[HELD_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_filtered_freq = r_out_freq;
    assign o_status        = r_out_status;
    assign o_samples_held  = r_out_held;

    // sample ring, read of the oldest entry in S_CHECK, write in S_JUMP
    ptf_ram #(
        .WIDTH (FREQ_W),
        .DEPTH (RING_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (w_sample18),
        .i_raddr (r_pos),
        .o_rdata (w_ram_rdata)
    );

    // shared divider: sample frequency, then mean of the ring
    ptf_serial_div #(
        .DENW (TIMER_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

endmodule

// ===== rtl/ptf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ptf_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ptf_pkg (t_div_req, DIV_NUM_W, DIV_CNT_W).
module ptf_serial_div
    import ptf_pkg::*;
#(
    parameter int DENW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_req             i_req,
    input  logic [DIV_NUM_W-1:0] i_dividend,   // left aligned
    input  logic [DENW-1:0]      i_divisor,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DENW-1:0]      r_rem;
    logic [DENW-1:0]      r_den;

    logic [DENW:0]        w_rem_sh;
    logic [DENW:0]        w_diff;
    logic                 w_qbit;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        w_rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_qbit   = ~w_diff[DENW];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem <= w_qbit ? w_diff[DENW-1:0] : w_rem_sh[DENW-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/ptf_checker.sv =====
// Port-level checker for the tachometer filter, bound to the top level.
// Depends on ptf_pkg (t_status codes, widths).
module ptf_checker
    import ptf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [FREQ_W-1:0]   o_filtered_freq,
    input logic [STATUS_W-1:0] o_status,
    input logic [HELD_W-1:0]   o_samples_held
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_filtered_freq) && $stable(o_status) && $stable(o_samples_held)))
        else $error("result changed while stalled");

    // one transaction in flight: busy right after an input is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second input taken while first in work");

    // a timed-out query reports an empty filter
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_QUERY_TIMEOUT) |->
            (o_filtered_freq == '0 && o_samples_held == '0))
        else $error("timed-out query reports data");

endmodule

bind pulse_period_tachometer_filter ptf_checker u_checker (.*);
